// ----- design/ngpar_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ngpar_pkg: shared types and constants
// Register map, sequencer states and fixed-point constants for the noise gate.
// ----------------------------------------------------------------------------
package ngpar_pkg;

	// register indexes, byte address = 4 * index
	localparam logic [1:0] REG_SMOOTH    = 2'd0;
	localparam logic [1:0] REG_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_ATTACK    = 2'd2;
	localparam logic [1:0] REG_RELEASE   = 2'd3;

	localparam int          ADDR_W      = 4;
	localparam int          DATA_W      = 32;
	localparam logic [16:0] GAIN_ONE    = 17'd65536;
	localparam logic [15:0] SMOOTH_RST  = 16'd1000;
	localparam logic [31:0] THRESH_RST  = 32'd4294967;
	localparam logic [16:0] ATTACK_RST  = 17'd27;
	localparam logic [16:0] RELEASE_RST = 17'd5;

	// serial multiplier: 4-bit digits of a 24-bit multiplier operand
	localparam int          DIGIT_W  = 4;
	localparam int          MULB_W   = 24;
	localparam logic [2:0]  DIGITS_C = 3'(MULB_W / DIGIT_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_PW,
		ST_PWC,
		ST_GN,
		ST_OUT,
		ST_DONE
	} ngpar_state_t;

endpackage

// ----- design/noise_gate_power_attack_release.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_gate_power_attack_release: per-channel noise gate
// Tracks a smoothed power per channel, opens or closes the gate against a
// threshold and slews the channel gain with attack and release steps.
// ----------------------------------------------------------------------------
//
//  port group   dir   payload                          transaction when
//  s_*          in    tdata: channel, sample_in        s_tvalid & s_tready
//  m_*          out   tdata: sample_out, channel_out;  m_tvalid & m_tready
//                     tuser: gate_open
//  APB          in    4 registers at 0x0, 0x4, 0x8, 0xC psel & penable & pwrite
//
//  An in-range sample passes from its acceptance through four products run
//  through one radix-16 serial multiplier, 6 digit steps each, with a finish
//  step after each product and a state between the power and gain products,
//  to the load of the output register. An out-of-range channel goes straight
//  from acceptance to the load. A new sample is accepted only after the last
//  one has been loaded into the output register.
//  The output register holds a result while the next sample is accepted; only
//  the final load waits on m_tready. Reset restores the register defaults,
//  zero power and full gain on all channels, and takes effect at once.
//
module noise_gate_power_attack_release #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// stream in
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,   // [2:0] channel, [26:3] sample_in
	// stream out
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // [23:0] sample_out, [26:24] channel_out
	output logic                          m_tuser,   // [0] gate_open
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ngpar_pkg::ADDR_W-1:0]  paddr,
	input  logic [ngpar_pkg::DATA_W-1:0]  pwdata,
	output logic [ngpar_pkg::DATA_W-1:0]  prdata,
	output logic                          pready
);
	import ngpar_pkg::*;

	localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	// configuration registers
	logic [15:0] smooth_q;
	logic [31:0] thresh_q;
	logic [16:0] attack_q;
	logic [16:0] release_q;

	// per-channel state
	logic [31:0] power_q [MAX_CHANNELS];
	logic [16:0] gain_st_q [MAX_CHANNELS];

	// sequencer and item registers
	ngpar_state_t        state_q, state_d;
	logic [2:0]          ch_q;
	logic signed [23:0]  x_q;
	logic                oor_q;
	logic [31:0]         pw_q;
	logic [16:0]         gain_q;
	logic                open_q;

	// serial multiplier
	logic signed [33:0]  a_q;
	logic [MULB_W-1:0]   b_q;
	logic signed [37:0]  hi_q;
	logic [MULB_W-1:0]   lo_q;
	logic [2:0]          cnt_q;

	// output register
	logic                m_tvalid_q;
	logic [23:0]         sout_q;
	logic [2:0]          chout_q;
	logic                gate_q;

	// ------------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------------
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q  <= SMOOTH_RST;
			thresh_q  <= THRESH_RST;
			attack_q  <= ATTACK_RST;
			release_q <= RELEASE_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_SMOOTH:    smooth_q  <= pwdata[15:0];
				REG_THRESHOLD: thresh_q  <= pwdata[31:0];
				REG_ATTACK:    attack_q  <= pwdata[16:0];
				REG_RELEASE:   release_q <= pwdata[16:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SMOOTH:    prdata = {16'd0, smooth_q};
			REG_THRESHOLD: prdata = thresh_q;
			REG_ATTACK:    prdata = {15'd0, attack_q};
			REG_RELEASE:   prdata = {15'd0, release_q};
			default:       prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// input decode
	// ------------------------------------------------------------------------
	logic [2:0]         in_ch;
	logic [23:0]        in_x;
	logic [23:0]        in_xabs;
	logic [5:0]         in_chx;
	logic               in_oor;
	logic [IDX_W-1:0]   in_idx;
	logic [5:0]         ch_x;
	logic [IDX_W-1:0]   idx;
	logic               accept;

	assign in_ch   = s_tdata[2:0];
	assign in_x    = s_tdata[26:3];
	// magnitude of a full-scale negative sample is 2^23, still fits 24 bits
	assign in_xabs = in_x[23] ? (~in_x + 24'd1) : in_x;
	assign in_chx  = {3'd0, in_ch};
	assign in_oor  = (in_chx >= 6'(MAX_CHANNELS));
	assign in_idx  = in_chx[IDX_W-1:0];
	assign ch_x    = {3'd0, ch_q};
	assign idx     = ch_x[IDX_W-1:0];
	assign accept  = s_tvalid & s_tready;

	// ------------------------------------------------------------------------
	// serial multiplier step: accumulate A * digit, shift one digit right
	// ------------------------------------------------------------------------
	logic signed [4:0]   digit;
	logic signed [37:0]  pp;
	logic signed [37:0]  psum;
	logic signed [61:0]  prod;
	logic                mul_done;

	assign digit    = $signed({1'b0, b_q[DIGIT_W-1:0]});
	assign pp       = a_q * digit;
	assign psum     = hi_q + pp;
	assign prod     = {hi_q, lo_q};
	assign mul_done = (cnt_q == DIGITS_C);

	// ------------------------------------------------------------------------
	// arithmetic between products
	// ------------------------------------------------------------------------
	logic [31:0]         sq_sat;
	logic signed [32:0]  pdiff;
	logic signed [35:0]  pw_sum;
	logic [31:0]         pw_new;
	logic                open_c;
	logic signed [17:0]  gdiff;
	logic [16:0]         step_f;
	logic signed [21:0]  g_sum;
	logic [16:0]         gain_new;

	// x*x in Q0.32 is the product shifted by 14, saturated at all ones
	assign sq_sat = (prod[47:46] != 2'd0) ? 32'hFFFF_FFFF : prod[45:14];
	assign pdiff  = $signed({1'b0, sq_sat}) - $signed({1'b0, pw_q});
	assign pw_sum = $signed({4'd0, pw_q}) + $signed(prod[51:16]);

	always_comb begin
		if (pw_sum[35])
			pw_new = '0;
		else if (pw_sum[34:32] != 3'd0)
			pw_new = 32'hFFFF_FFFF;
		else
			pw_new = pw_sum[31:0];
	end

	assign open_c = (pw_q >= thresh_q);
	assign gdiff  = (open_c ? $signed({1'b0, GAIN_ONE}) : 18'sd0) - $signed({1'b0, gain_q});
	assign step_f = (gdiff > 18'sd0) ? attack_q : release_q;
	assign g_sum  = $signed({5'd0, gain_q}) + $signed(prod[37:16]);

	always_comb begin
		if (g_sum[21])
			gain_new = '0;
		else if (g_sum > $signed({5'd0, GAIN_ONE}))
			gain_new = GAIN_ONE;
		else
			gain_new = g_sum[16:0];
	end

	// ------------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------------
	logic out_free;
	assign out_free = ~m_tvalid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid)
					state_d = in_oor ? ST_DONE : ST_SQ;
			end
			ST_SQ:   if (mul_done) state_d = ST_PW;
			ST_PW:   if (mul_done) state_d = ST_PWC;
			ST_PWC:  state_d = ST_GN;
			ST_GN:   if (mul_done) state_d = ST_OUT;
			ST_OUT:  if (mul_done) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// multiplier control: load operands at the start of each product, else step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= DIGITS_C;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) cnt_q <= '0;
				ST_SQ, ST_GN: begin
					if (mul_done)
						cnt_q <= (state_q == ST_GN) ? 3'd0 : 3'd0;
					else
						cnt_q <= cnt_q + 3'd1;
				end
				ST_PW: if (!mul_done) cnt_q <= cnt_q + 3'd1;
				ST_PWC: cnt_q <= '0;
				ST_OUT: if (!mul_done) cnt_q <= cnt_q + 3'd1;
				default: ;
			endcase
		end
	end

	// multiplier datapath and item registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ch_q   <= in_ch;
					x_q    <= $signed(in_x);
					oor_q  <= in_oor;
					pw_q   <= power_q[in_idx];
					gain_q <= gain_st_q[in_idx];
					a_q    <= $signed({10'd0, in_xabs});
					b_q    <= in_xabs;
					hi_q   <= '0;
					lo_q   <= '0;
				end
			end
			ST_SQ: begin
				if (mul_done) begin
					// power update: alpha * (p - pw)
					a_q  <= 34'(pdiff);
					b_q  <= {8'd0, smooth_q};
					hi_q <= '0;
					lo_q <= '0;
				end
			end
			ST_PW: begin
				if (mul_done)
					pw_q <= pw_new;
			end
			ST_PWC: begin
				// gain update: step * (target - gain)
				open_q <= open_c;
				a_q    <= 34'(gdiff);
				b_q    <= {7'd0, step_f};
				hi_q   <= '0;
				lo_q   <= '0;
			end
			ST_GN: begin
				if (mul_done) begin
					gain_q <= gain_new;
					a_q    <= 34'(x_q);
					b_q    <= {7'd0, gain_new};
					hi_q   <= '0;
					lo_q   <= '0;
				end
			end
			default: ;
		endcase
		if ((state_q == ST_SQ || state_q == ST_PW || state_q == ST_GN || state_q == ST_OUT)
			&& !mul_done) begin
			hi_q <= psum >>> DIGIT_W;
			lo_q <= {psum[DIGIT_W-1:0], lo_q[MULB_W-1:DIGIT_W]};
			b_q  <= b_q >> DIGIT_W;
		end
	end

	// per-channel state: write back power and gain at the end of each update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				power_q[i]   <= '0;
				gain_st_q[i] <= GAIN_ONE;
			end
		end else begin
			if (state_q == ST_PW && mul_done)
				power_q[idx] <= pw_new;
			if (state_q == ST_GN && mul_done)
				gain_st_q[idx] <= gain_new;
		end
	end

	// ------------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------------
	logic out_load;
	assign out_load = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			// out-of-range channels pass the sample through with the gate closed
			sout_q  <= oor_q ? x_q : prod[39:16];
			chout_q <= ch_q;
			gate_q  <= oor_q ? 1'b0 : open_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, chout_q, sout_q};
	assign m_tuser  = gate_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input taken while an item is in flight");

	a_digit_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DIGITS_C)
		else $error("multiplier digit count out of range");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (gain_q <= GAIN_ONE))
		else $error("channel gain above full scale");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_DONE))
		else $error("result presented without a finished item");

endmodule
